### src/vfc_pkg.sv
// Shared types, constants and layouts for the voxel face culling block.
`default_nettype none

package vfc_pkg;

    localparam int CHUNK_WIDTH  = 16;
    localparam int CHUNK_HEIGHT = 128;

    localparam int POS_XW = 4;
    localparam int POS_YW = 7;
    localparam int POS_ZW = 4;
    localparam int KIND_W = 8;
    localparam int FACE_N = 6;
    localparam int CNT_W  = 3;

    // occupancy is stored one z-row per word
    localparam int ROW_W   = 2 ** POS_ZW;
    localparam int ROW_AW  = POS_XW + POS_YW;
    localparam int ROWS    = 2 ** ROW_AW;
    localparam int CELL_AW = ROW_AW + POS_ZW;
    localparam int CELLS   = 2 ** CELL_AW;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    localparam int OUT_SOLID_BIT = 0;
    localparam int OUT_KIND_LSB  = OUT_SOLID_BIT + 1;
    localparam int OUT_MASK_LSB  = OUT_KIND_LSB + KIND_W;
    localparam int OUT_CNT_LSB   = OUT_MASK_LSB + FACE_N;
    localparam int OUT_USED_W    = OUT_CNT_LSB + CNT_W;

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        CLS_WRITE,
        CLS_QUERY,
        CLS_EMPTY
    } cls_t;

    typedef struct packed {
        cls_t                cls;
        logic [POS_XW-1:0]   x;
        logic [POS_YW-1:0]   y;
        logic [POS_ZW-1:0]   z;
        logic                solid;
        logic [KIND_W-1:0]   kind;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

    typedef struct packed {
        logic pop;
        logic busy;
    } back_ctl_t;

    typedef enum logic [2:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_RD1,
        BS_RD2,
        BS_RD3,
        BS_DONE
    } bstate_t;

endpackage

`default_nettype wire

### src/vfc_front.sv
// Input side: accepts transfers, classifies them and queues them for the back end.
`default_nettype none

module vfc_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [vfc_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire logic                           s_tuser,
    input  wire vfc_pkg::back_ctl_t             back_ctl,
    output vfc_pkg::head_t                      head
);
    import vfc_pkg::*;

    item_t             q_reg [QDEPTH];
    logic [QAW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]    cnt_reg, cnt_next;

    logic [POS_XW-1:0] in_x;
    logic [POS_YW-1:0] in_y;
    logic [POS_ZW-1:0] in_z;
    logic              in_solid;
    logic [KIND_W-1:0] in_kind;
    logic              in_chunk;
    logic              take;
    logic              push;
    logic              pop;
    item_t             in_item;

    assign in_x     = s_tdata[POS_XW-1:0];
    assign in_y     = s_tdata[POS_XW +: POS_YW];
    assign in_z     = s_tdata[POS_XW+POS_YW +: POS_ZW];
    assign in_solid = s_tdata[POS_XW+POS_YW+POS_ZW];
    assign in_kind  = s_tdata[POS_XW+POS_YW+POS_ZW+1 +: KIND_W];

    assign in_chunk = ({1'b0, in_x} < (POS_XW+1)'(CHUNK_WIDTH))
                   && ({1'b0, in_y} < (POS_YW+1)'(CHUNK_HEIGHT))
                   && ({1'b0, in_z} < (POS_ZW+1)'(CHUNK_WIDTH));

    always_comb
    begin
        in_item.x     = in_x;
        in_item.y     = in_y;
        in_item.z     = in_z;
        in_item.solid = in_solid;
        in_item.kind  = in_kind;
        if (s_tuser == OP_WRITE)
        begin
            in_item.cls = CLS_WRITE;
        end
        else if (in_chunk)
        begin
            in_item.cls = CLS_QUERY;
        end
        else
        begin
            in_item.cls = CLS_EMPTY;
        end
    end

    assign s_tready = (cnt_reg != QCW'(QDEPTH)) && !back_ctl.busy;
    assign take     = s_tvalid && s_tready;
    // writes outside the chunk are dropped here
    assign push     = take && !(s_tuser == OP_WRITE && !in_chunk);
    assign pop      = back_ctl.pop && (cnt_reg != '0);

    assign head.valid = (cnt_reg != '0);
    assign head.item  = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + QCW'(push) - QCW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

### src/vfc_back.sv
// Back end: voxel stores, clearing pass, neighbour reads and the result register.
`default_nettype none

module vfc_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire vfc_pkg::head_t                  head,
    output vfc_pkg::back_ctl_t                   back_ctl,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [vfc_pkg::OUT_DATA_W-1:0]       m_tdata
);
    import vfc_pkg::*;

    // occupancy and written flags, one z-row per word; types one per voxel
    logic [ROW_W-1:0]  occ_mem [ROWS];
    logic [ROW_W-1:0]  wrt_mem [ROWS];
    logic [KIND_W-1:0] typ_mem [CELLS];

    bstate_t           state_reg, state_next;
    logic [ROW_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;

    item_t             item_reg;
    logic [ROW_W-1:0]  rd_a_reg, rd_b_reg, wrt_rd_reg;
    logic [KIND_W-1:0] typ_rd_reg;
    logic              occ_c_reg, occ_zp_reg, occ_zm_reg, occ_xp_reg;
    logic              occ_xm_reg, occ_yp_reg, occ_ym_reg, wrt_c_reg;

    item_t             cur;
    logic [ROW_AW-1:0] addr_a, addr_b;
    logic              rd_en;
    logic              clr_we;
    logic              wr_we;
    logic              pop;
    logic              load_item;
    logic              out_free;
    logic              out_load;
    logic [OUT_DATA_W-1:0] out_data_next;

    logic [POS_XW-1:0] x_p, x_m;
    logic [POS_YW-1:0] y_p, y_m;
    logic [POS_ZW-1:0] z_p, z_m;
    logic [FACE_N-1:0] mask;
    logic [CNT_W-1:0]  count;
    logic [KIND_W-1:0] kind_q;

    assign out_free = !out_valid_reg || m_tready;
    assign cur      = (state_reg == BS_IDLE) ? head.item : item_reg;

    assign x_p = cur.x + POS_XW'(1);
    assign x_m = cur.x - POS_XW'(1);
    assign y_p = cur.y + POS_YW'(1);
    assign y_m = cur.y - POS_YW'(1);
    assign z_p = item_reg.z + POS_ZW'(1);
    assign z_m = item_reg.z - POS_ZW'(1);

    always_comb
    begin
        if (occ_c_reg)
        begin
            mask[0] = (item_reg.z == POS_ZW'(CHUNK_WIDTH - 1)) || !occ_zp_reg;
            mask[1] = (item_reg.z == '0) || !occ_zm_reg;
            mask[2] = (item_reg.x == POS_XW'(CHUNK_WIDTH - 1)) || !occ_xp_reg;
            mask[3] = (item_reg.x == '0) || !occ_xm_reg;
            mask[4] = (item_reg.y != POS_YW'(CHUNK_HEIGHT - 1)) && !occ_yp_reg;
            mask[5] = (item_reg.y != '0) && !occ_ym_reg;
        end
        else
        begin
            mask = '0;
        end
        count = CNT_W'(mask[0]) + CNT_W'(mask[1]) + CNT_W'(mask[2])
              + CNT_W'(mask[3]) + CNT_W'(mask[4]) + CNT_W'(mask[5]);
        kind_q = wrt_c_reg ? typ_rd_reg : '0;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        addr_a         = {cur.x, cur.y};
        addr_b         = {x_p, cur.y};
        rd_en          = 1'b0;
        clr_we         = 1'b0;
        wr_we          = 1'b0;
        pop            = 1'b0;
        load_item      = 1'b0;
        out_load       = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            BS_CLEAR:
            begin
                clr_we       = 1'b1;
                addr_a       = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + ROW_AW'(1);
                if (clr_cnt_reg == ROW_AW'(ROWS - 1))
                begin
                    state_next = BS_IDLE;
                end
            end
            BS_IDLE:
            begin
                if (head.valid)
                begin
                    unique case (head.item.cls)
                        CLS_WRITE:
                        begin
                            wr_we = 1'b1;
                            pop   = 1'b1;
                        end
                        CLS_QUERY:
                        begin
                            rd_en      = 1'b1;
                            pop        = 1'b1;
                            load_item  = 1'b1;
                            state_next = BS_RD1;
                        end
                        CLS_EMPTY:
                        begin
                            if (out_free)
                            begin
                                pop            = 1'b1;
                                out_load       = 1'b1;
                                out_valid_next = 1'b1;
                                out_data_next  = '0;
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            BS_RD1:
            begin
                rd_en      = 1'b1;
                addr_a     = {x_m, cur.y};
                addr_b     = {cur.x, y_p};
                state_next = BS_RD2;
            end
            BS_RD2:
            begin
                rd_en      = 1'b1;
                addr_a     = {cur.x, y_m};
                state_next = BS_RD3;
            end
            BS_RD3:
            begin
                state_next = BS_DONE;
            end
            BS_DONE:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_DATA_W'({count, mask, kind_q, occ_c_reg});
                    state_next     = BS_IDLE;
                end
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // stores
    always_ff @(posedge clk)
    begin
        if (clr_we)
        begin
            occ_mem[addr_a] <= '0;
            wrt_mem[addr_a] <= '0;
        end
        else if (wr_we)
        begin
            occ_mem[addr_a][head.item.z] <= head.item.solid;
            wrt_mem[addr_a][head.item.z] <= 1'b1;
        end
        if (rd_en)
        begin
            rd_a_reg <= occ_mem[addr_a];
            rd_b_reg <= occ_mem[addr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_we)
        begin
            typ_mem[{head.item.x, head.item.y, head.item.z}] <= head.item.kind;
        end
        if (load_item)
        begin
            typ_rd_reg <= typ_mem[{head.item.x, head.item.y, head.item.z}];
            wrt_rd_reg <= wrt_mem[addr_a];
        end
    end

    // neighbour capture
    always_ff @(posedge clk)
    begin
        if (load_item)
        begin
            item_reg <= head.item;
        end
        if (state_reg == BS_RD1)
        begin
            occ_c_reg  <= rd_a_reg[item_reg.z];
            occ_zp_reg <= rd_a_reg[z_p];
            occ_zm_reg <= rd_a_reg[z_m];
            occ_xp_reg <= rd_b_reg[item_reg.z];
            wrt_c_reg  <= wrt_rd_reg[item_reg.z];
        end
        if (state_reg == BS_RD2)
        begin
            occ_xm_reg <= rd_a_reg[item_reg.z];
            occ_yp_reg <= rd_b_reg[item_reg.z];
        end
        if (state_reg == BS_RD3)
        begin
            occ_ym_reg <= rd_a_reg[item_reg.z];
        end
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign back_ctl.pop  = pop;
    assign back_ctl.busy = (state_reg == BS_CLEAR);
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_data_reg;

endmodule

`default_nettype wire

### src/voxel_face_culling.sv
// Top level of the voxel face culling block.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tuser opcode, s_tdata position, solid, kind
//  m_      | out | m_tvalid/m_tready  | m_tdata solid, kind, face mask, face count
//
// IDLE handles writes and empty queries, and a query passes IDLE, RD1, RD2, RD3 and
// DONE: the occupancy store has two read ports and the seven neighbour bits need three
// reads. After reset a clearing pass over all 2048 occupancy rows, one row per cycle, runs
// with s_tready low. A two-entry queue separates input from the back end; the result
// register lets writes and next-query reads go on while a result waits on m_tready.
`default_nettype none

module voxel_face_culling (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [vfc_pkg::IN_DATA_W-1:0]  s_tdata,   // pos_x, pos_y, pos_z, solid, kind
    input  wire logic                           s_tuser,   // opcode
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [vfc_pkg::OUT_DATA_W-1:0]      m_tdata    // voxel_solid, voxel_kind,
                                                           // face_mask, face_count, zero pad
);
    import vfc_pkg::*;

    head_t     head;
    back_ctl_t back_ctl;

    vfc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .back_ctl (back_ctl),
        .head     (head)
    );

    vfc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .back_ctl (back_ctl),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

### src/vfc_checker.sv
// Port checks for the voxel face culling block, bound to the top level.
`default_nettype none

module vfc_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [vfc_pkg::OUT_DATA_W-1:0] m_tdata
);
    import vfc_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn before transfer");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $countones(m_tdata[OUT_MASK_LSB +: FACE_N])
                     == int'(m_tdata[OUT_CNT_LSB +: CNT_W]))
        else $error("face count disagrees with face mask");

    a_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[OUT_SOLID_BIT] |-> m_tdata[OUT_MASK_LSB +: FACE_N] == '0)
        else $error("faces reported for an inactive voxel");

endmodule

bind voxel_face_culling vfc_checker u_vfc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
